FILE: rtl/lsx_pkg.sv
// Shared constants, codes and types for the line/statement cross-reference table.
package lsx_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int KEY_W    = 16;
    localparam int NUM_W    = 16;
    localparam int ACT_W    = 3;
    localparam int STAT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_PUT_LINE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUT_STMT     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LINE_OF_TOK  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_STMT_OF_TOK  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TOK_OF_STMT  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_STMT_OF_LINE = 3'd5;
    localparam logic [ACT_W-1:0] ACT_NEXT_LINE    = 3'd6;
    localparam logic [ACT_W-1:0] ACT_TOK_HAS_LINE = 3'd7;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    // query beat travelling down the chain, with running search results
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] token;
        logic [NUM_W-1:0] value;
        logic             hit;
        logic [KEY_W-1:0] best_key;
        logic [NUM_W-1:0] best_num;
        logic [IDX_W-1:0] idx;
        logic             free_hit;
        logic [IDX_W-1:0] free_idx;
    } pkt_t;

    // entry update broadcast to all cells
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             alloc;
        logic             set_line;
        logic             set_stmt;
        logic [KEY_W-1:0] token;
        logic [NUM_W-1:0] value;
    } wr_t;

endpackage

FILE: rtl/lsx_cell.sv
// One table entry plus one stage of the query chain.
module lsx_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [lsx_pkg::IDX_W-1:0] cell_idx,
    input  logic                      vld_in,
    input  lsx_pkg::pkt_t             pkt_in,
    output logic                      vld_out,
    output lsx_pkg::pkt_t             pkt_out,
    input  logic                      wr_valid,
    input  lsx_pkg::wr_t              wr
);
    import lsx_pkg::*;

    logic             used_reg, used_next;
    logic             has_line_reg, has_line_next;
    logic             has_stmt_reg, has_stmt_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [NUM_W-1:0] line_reg, line_next;
    logic [NUM_W-1:0] stmt_reg, stmt_next;
    logic             vld_reg;
    pkt_t             pkt_reg, pkt_next;
    logic             wr_sel;
    logic             key_match;
    logic             cand;

    assign wr_sel = wr_valid && (wr.idx == cell_idx);

    always_comb
    begin
        used_next     = used_reg;
        has_line_next = has_line_reg;
        has_stmt_next = has_stmt_reg;
        key_next      = key_reg;
        line_next     = line_reg;
        stmt_next     = stmt_reg;
        if (wr_sel)
        begin
            if (wr.alloc)
            begin
                used_next     = 1'b1;
                key_next      = wr.token;
                has_line_next = 1'b0;
                has_stmt_next = 1'b0;
            end
            if (wr.set_line)
            begin
                has_line_next = 1'b1;
                line_next     = wr.value;
            end
            if (wr.set_stmt)
            begin
                has_stmt_next = 1'b1;
                stmt_next     = wr.value;
            end
        end
    end

    always_comb
    begin
        pkt_next  = pkt_in;
        key_match = used_reg && (key_reg == pkt_in.token);
        cand      = 1'b0;
        case (pkt_in.action)
            ACT_PUT_LINE, ACT_PUT_STMT:
            begin
                if (key_match)
                begin
                    pkt_next.hit = 1'b1;
                    pkt_next.idx = cell_idx;
                end
                if (!used_reg && !pkt_in.free_hit)
                begin
                    pkt_next.free_hit = 1'b1;
                    pkt_next.free_idx = cell_idx;
                end
            end
            ACT_LINE_OF_TOK, ACT_TOK_HAS_LINE:
            begin
                if (key_match)
                begin
                    pkt_next.hit      = has_line_reg;
                    pkt_next.best_num = line_reg;
                end
            end
            ACT_STMT_OF_TOK:
            begin
                if (key_match)
                begin
                    pkt_next.hit      = has_stmt_reg;
                    pkt_next.best_num = stmt_reg;
                end
            end
            ACT_TOK_OF_STMT:
            begin
                cand = used_reg && has_stmt_reg && (stmt_reg == pkt_in.value);
                if (cand && (!pkt_in.hit || key_reg < pkt_in.best_key))
                begin
                    pkt_next.hit      = 1'b1;
                    pkt_next.best_key = key_reg;
                end
            end
            ACT_STMT_OF_LINE:
            begin
                cand = used_reg && has_line_reg && has_stmt_reg
                       && (line_reg == pkt_in.value);
                if (cand && (!pkt_in.hit || key_reg < pkt_in.best_key))
                begin
                    pkt_next.hit      = 1'b1;
                    pkt_next.best_key = key_reg;
                    pkt_next.best_num = stmt_reg;
                end
            end
            ACT_NEXT_LINE:
            begin
                cand = used_reg && has_line_reg && (line_reg > pkt_in.value);
                if (cand && (!pkt_in.hit || line_reg < pkt_in.best_num))
                begin
                    pkt_next.hit      = 1'b1;
                    pkt_next.best_num = line_reg;
                end
            end
            default:
            begin
                pkt_next = pkt_in;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= 1'b0;
            has_line_reg <= 1'b0;
            has_stmt_reg <= 1'b0;
            vld_reg      <= 1'b0;
        end
        else
        begin
            used_reg     <= used_next;
            has_line_reg <= has_line_next;
            has_stmt_reg <= has_stmt_next;
            vld_reg      <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        line_reg <= line_next;
        stmt_reg <= stmt_next;
        pkt_reg  <= pkt_next;
    end

    assign vld_out = vld_reg;
    assign pkt_out = pkt_reg;

endmodule

FILE: rtl/lsx_ctrl.sv
// Command sequencer: launches a query into the chain and turns the tail beat into a result.
module lsx_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [lsx_pkg::ACT_W-1:0]  action,
    input  logic [lsx_pkg::KEY_W-1:0]  token,
    input  logic [lsx_pkg::NUM_W-1:0]  value,
    output logic                       head_vld,
    output lsx_pkg::pkt_t              head_pkt,
    input  logic                       tail_vld,
    input  lsx_pkg::pkt_t              tail_pkt,
    output logic                       wr_valid,
    output lsx_pkg::wr_t               wr,
    output logic                       done,
    output logic [lsx_pkg::NUM_W-1:0]  answer,
    output logic [lsx_pkg::STAT_W-1:0] status
);
    import lsx_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic              state_reg, state_next;
    logic              head_vld_reg;
    pkt_t              head_pkt_reg, head_pkt_next;
    logic              done_reg;
    logic [NUM_W-1:0]  answer_reg, answer_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              wr_valid_reg, wr_valid_next;
    wr_t               wr_reg, wr_next;
    logic              accept;

    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        head_pkt_next          = '0;
        head_pkt_next.action   = action;
        head_pkt_next.token    = token;
        head_pkt_next.value    = value;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tail_vld)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        answer_next    = '0;
        status_next    = STAT_OK;
        wr_valid_next  = 1'b0;
        wr_next.idx      = tail_pkt.hit ? tail_pkt.idx : tail_pkt.free_idx;
        wr_next.alloc    = !tail_pkt.hit;
        wr_next.set_line = (tail_pkt.action == ACT_PUT_LINE);
        wr_next.set_stmt = (tail_pkt.action == ACT_PUT_STMT);
        wr_next.token    = tail_pkt.token;
        wr_next.value    = tail_pkt.value;
        case (tail_pkt.action)
            ACT_PUT_LINE, ACT_PUT_STMT:
            begin
                if (tail_pkt.hit || tail_pkt.free_hit)
                begin
                    wr_valid_next = tail_vld;
                end
                else
                begin
                    status_next = STAT_FULL;
                end
            end
            ACT_LINE_OF_TOK, ACT_STMT_OF_TOK, ACT_STMT_OF_LINE:
            begin
                if (tail_pkt.hit)
                begin
                    answer_next = tail_pkt.best_num;
                end
                else
                begin
                    status_next = STAT_NOT_FOUND;
                end
            end
            ACT_TOK_OF_STMT:
            begin
                if (tail_pkt.hit)
                begin
                    answer_next = NUM_W'(tail_pkt.best_key);
                end
                else
                begin
                    status_next = STAT_NOT_FOUND;
                end
            end
            ACT_NEXT_LINE:
            begin
                answer_next = tail_pkt.hit ? tail_pkt.best_num : '0;
            end
            default:
            begin
                answer_next = NUM_W'(tail_pkt.hit);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_vld_reg <= accept;
            done_reg     <= tail_vld;
            wr_valid_reg <= wr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_pkt_reg <= head_pkt_next;
        end
        if (tail_vld)
        begin
            answer_reg <= answer_next;
            status_reg <= status_next;
            wr_reg     <= wr_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign head_vld = head_vld_reg;
    assign head_pkt = head_pkt_reg;
    assign wr_valid = wr_valid_reg;
    assign wr       = wr_reg;
    assign done     = done_reg;
    assign answer   = answer_reg;
    assign status   = status_reg;

endmodule

FILE: rtl/line_statement_xref_table.sv
// Top level of the line/statement cross-reference table: sequencer plus a chain of entry cells.
//
// Command port: a beat (action, token, value) is taken at a rising edge where start is
// high and busy is low. busy rises right after and stays high while the query runs.
// Result port: done is high for exactly one cycle with answer and status valid; the
// receiver must take it then, there is no back-pressure.
// The query walks the chain of CAPACITY cells, one cell per cycle; each cell holds
// one entry and folds it into the running search (key match, first free entry,
// lowest matching token, smallest line above). Stores are applied by a broadcast
// write issued in the same cycle as done.
// busy is low during the done cycle, so the next command can be taken at the edge that
// ends it. Only one command is in the chain at a time, and a beat visits every cell once.
// Reset: all entry marks clear at once, so the table is empty and ready as soon as
// rst_n is released; no clearing pass.
module line_statement_xref_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [lsx_pkg::ACT_W-1:0]  action,
    input  logic [lsx_pkg::KEY_W-1:0]  token,
    input  logic [lsx_pkg::NUM_W-1:0]  value,
    output logic                       done,
    output logic [lsx_pkg::NUM_W-1:0]  answer,
    output logic [lsx_pkg::STAT_W-1:0] status
);
    import lsx_pkg::*;

    logic vld_chain [0:CAPACITY];
    pkt_t pkt_chain [0:CAPACITY];
    logic wr_valid;
    wr_t  wr;

    lsx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .action   (action),
        .token    (token),
        .value    (value),
        .head_vld (vld_chain[0]),
        .head_pkt (pkt_chain[0]),
        .tail_vld (vld_chain[CAPACITY]),
        .tail_pkt (pkt_chain[CAPACITY]),
        .wr_valid (wr_valid),
        .wr       (wr),
        .done     (done),
        .answer   (answer),
        .status   (status)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        lsx_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(i)),
            .vld_in   (vld_chain[i]),
            .pkt_in   (pkt_chain[i]),
            .vld_out  (vld_chain[i+1]),
            .pkt_out  (pkt_chain[i+1]),
            .wr_valid (wr_valid),
            .wr       (wr)
        );
    end

endmodule
